// File: design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

   // access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam int CSR_DATA_W = 5;

   localparam logic [4:0] OFFSET_BITS_RST = 5'd5;
   localparam logic [3:0] INDEX_BITS_RST  = 4'd8;
   localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

   // widest set index and tag over the parameter ranges
   localparam int SET_MAX_W = 16;
   localparam int TAG_MAX_W = 64;
   localparam int VICTIM_W  = 48;
   localparam int COUNT_W   = 32;

   // classified access word, front to back
   typedef struct packed {
      logic                 kind;
      logic [SET_MAX_W-1:0] set;
      logic [TAG_MAX_W-1:0] tag;
   } item_type;

endpackage

`default_nettype wire

// File: design/sacl_front.sv
// ----------------------------------------------------------------------------
// sacl_front
// Holds the csr registers and splits each request address into set and tag.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_front #(
   parameter int SETS      = 256,
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 48,
   localparam int WCNT_W   = $clog2(WAYS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                          req_kind,
   input  wire logic [ADDR_BITS-1:0]          req_address,
   output sacl_pkg::item_type                 item,
   output logic [WCNT_W-1:0]                  ways_eff
);

   // floor(log2(SETS))
   localparam int MAX_IB = $clog2(SETS + 1) - 1;

   logic [4:0]           offset_bits_ff;
   logic [3:0]           index_bits_ff;
   logic [3:0]           ways_in_use_ff;
   logic [4:0]           ib_eff;
   logic [5:0]           tag_shift;
   logic [15:0]          set_mask;
   logic [ADDR_BITS-1:0] addr_off;
   logic [ADDR_BITS-1:0] tag_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= sacl_pkg::OFFSET_BITS_RST;
         index_bits_ff  <= sacl_pkg::INDEX_BITS_RST;
         ways_in_use_ff <= sacl_pkg::WAYS_IN_USE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sacl_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata[4:0];
            sacl_pkg::CSR_INDEX_BITS:  index_bits_ff  <= csr_wdata[3:0];
            sacl_pkg::CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ib_eff = (5'(index_bits_ff) > 5'(MAX_IB)) ? 5'(MAX_IB) : 5'(index_bits_ff);
      tag_shift = 6'(offset_bits_ff) + 6'(ib_eff);
      set_mask  = ~(16'hffff << ib_eff);
      addr_off  = req_address >> offset_bits_ff;
      tag_raw   = req_address >> tag_shift;

      item.kind = req_kind;
      item.set  = addr_off[15:0] & set_mask;
      item.tag  = sacl_pkg::TAG_MAX_W'(tag_raw);

      if (ways_in_use_ff == 4'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (32'(ways_in_use_ff) > WAYS) begin
         ways_eff = WCNT_W'(WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_in_use_ff);
      end
   end

endmodule

`default_nettype wire

// File: design/sacl_queue.sv
// ----------------------------------------------------------------------------
// sacl_queue
// Two-entry queue of classified access words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sacl_pkg::item_type push_item,
   input  wire logic               pop,
   output logic                    not_empty,
   output logic                    full,
   output sacl_pkg::item_type      head
);

   sacl_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/sacl_back.sv
// ----------------------------------------------------------------------------
// sacl_back
// Reads a set row, finds hit / free / LRU way, writes the row back and
// registers the response word. Clears valid and age rows after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_back #(
   parameter int SETS      = 256,
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 48,
   localparam int WCNT_W   = $clog2(WAYS + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_not_empty,
   input  wire sacl_pkg::item_type               q_head,
   output logic                                  q_pop,
   input  wire logic [WCNT_W-1:0]                ways_eff,
   output logic                                  clearing,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_hit,
   output logic [2:0]                            rsp_way,
   output logic                                  rsp_evicted,
   output logic [sacl_pkg::VICTIM_W-1:0]         rsp_victim_tag,
   output logic [sacl_pkg::COUNT_W-1:0]          rsp_read_hits,
   output logic [sacl_pkg::COUNT_W-1:0]          rsp_write_hits
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W = WAY_W;
   localparam int TAG_W = ADDR_BITS;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;

   // set-row memories
   logic [WAYS-1:0]       valid_mem_ff [SETS];
   logic [WAYS*AGE_W-1:0] age_mem_ff   [SETS];
   logic [WAYS*TAG_W-1:0] tag_mem_ff   [SETS];

   logic [WAYS-1:0]       vld_rd_ff;
   logic [WAYS*AGE_W-1:0] age_rd_ff;
   logic [WAYS*TAG_W-1:0] tag_rd_ff;

   logic             cur_kind_ff;
   logic [SET_W-1:0] cur_set_ff;
   logic [TAG_W-1:0] cur_tag_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          hit_ff;
   logic [2:0]                    way_ff;
   logic                          evicted_ff;
   logic [sacl_pkg::VICTIM_W-1:0] victim_ff;
   logic [sacl_pkg::COUNT_W-1:0]  read_hits_ff, read_hits_in;
   logic [sacl_pkg::COUNT_W-1:0]  write_hits_ff, write_hits_in;

   logic                  finish;
   logic [WAYS-1:0]       way_on;
   logic [AGE_W-1:0]      age_of [WAYS];
   logic [TAG_W-1:0]      tag_of [WAYS];
   logic                  hit_found, free_found;
   logic [WAY_W-1:0]      hit_way, free_way, lru_way, target;
   logic [AGE_W-1:0]      best_age, t_age;
   logic                  was_valid;
   logic [WAYS-1:0]       vld_new;
   logic [WAYS*AGE_W-1:0] age_new;
   logic [WAYS*TAG_W-1:0] tag_new;
   logic [TAG_W-1:0]      victim_full;

   assign clearing = (state_ff == ST_CLEAR);
   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty;
   // response slot free or draining this cycle
   assign finish   = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // way search and recency update over the row just read
   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      lru_way    = '0;
      best_age   = '0;
      for (int w = 0; w < WAYS; w++) begin
         way_on[w] = (WCNT_W'(w) < ways_eff);
         age_of[w] = age_rd_ff[w*AGE_W +: AGE_W];
         tag_of[w] = tag_rd_ff[w*TAG_W +: TAG_W];
      end
      for (int w = 0; w < WAYS; w++) begin
         if (way_on[w] && vld_rd_ff[w] && (tag_of[w] == cur_tag_ff) && !hit_found) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (way_on[w] && !vld_rd_ff[w] && !free_found) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
         // strict compare keeps the lowest way among equal ages
         if (way_on[w] && (age_of[w] > best_age)) begin
            best_age = age_of[w];
            lru_way  = WAY_W'(w);
         end
      end

      priority if (hit_found) begin
         target = hit_way;
      end else if (free_found) begin
         target = free_way;
      end else begin
         target = lru_way;
      end

      was_valid   = vld_rd_ff[target];
      t_age       = age_of[target];
      victim_full = (!hit_found && !free_found) ? tag_of[target] : '0;

      vld_new = vld_rd_ff;
      age_new = age_rd_ff;
      tag_new = tag_rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (way_on[w] && (WAY_W'(w) != target) && vld_rd_ff[w]
             && !(was_valid && (age_of[w] >= t_age)) && (age_of[w] < AGE_MAX)) begin
            age_new[w*AGE_W +: AGE_W] = age_of[w] + AGE_W'(1);
         end
      end
      vld_new[target]                 = 1'b1;
      age_new[target*AGE_W +: AGE_W]  = '0;
      tag_new[target*TAG_W +: TAG_W]  = cur_tag_ff;

      read_hits_in  = read_hits_ff;
      write_hits_in = write_hits_ff;
      if (finish && hit_found) begin
         if (cur_kind_ff == sacl_pkg::KIND_WRITE) begin
            write_hits_in = write_hits_ff + sacl_pkg::COUNT_W'(1);
         end else begin
            read_hits_in = read_hits_ff + sacl_pkg::COUNT_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // row memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         valid_mem_ff[clr_ff] <= '0;
         age_mem_ff[clr_ff]   <= '0;
      end else if (finish) begin
         valid_mem_ff[cur_set_ff] <= vld_new;
         age_mem_ff[cur_set_ff]   <= age_new;
         tag_mem_ff[cur_set_ff]   <= tag_new;
      end
      if (q_pop) begin
         vld_rd_ff <= valid_mem_ff[q_head.set[SET_W-1:0]];
         age_rd_ff <= age_mem_ff[q_head.set[SET_W-1:0]];
         tag_rd_ff <= tag_mem_ff[q_head.set[SET_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_kind_ff <= q_head.kind;
         cur_set_ff  <= q_head.set[SET_W-1:0];
         cur_tag_ff  <= q_head.tag[TAG_W-1:0];
      end
      if (finish) begin
         hit_ff     <= hit_found;
         way_ff     <= 3'(target);
         evicted_ff <= !hit_found && !free_found;
         victim_ff  <= sacl_pkg::VICTIM_W'(victim_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         read_hits_ff  <= '0;
         write_hits_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         read_hits_ff  <= read_hits_in;
         write_hits_ff <= write_hits_in;
      end
   end

   // counters only move when a new word loads, so they hold with it
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_way        = way_ff;
   assign rsp_evicted    = evicted_ff;
   assign rsp_victim_tag = victim_ff;
   assign rsp_read_hits  = read_hits_ff;
   assign rsp_write_hits = write_hits_ff;

endmodule

`default_nettype wire

// File: design/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with least-recently-used replacement.
//
// Requests (req_valid/req_ready) carry an access kind and a byte address; each
// request yields one response word (rsp_valid/rsp_ready) with hit, way, the
// evicted tag and the running read/write hit counts. csr_we writes the offset
// bit count, index bit count or ways in use at csr_index, with no wait.
// The back end serves one request at a time by a read-modify-write of a
// set row: a registered row read, then search, recency update and write
// back; the queue takes further requests meanwhile. Between acceptance and
// rsp_valid lie the queue entry, the row read and the response registers.
// After reset a clearing pass over all SETS rows zeroes the valid and age rows;
// req_ready stays low until it is done. csr writes are taken during it.
// A stalled receiver holds the response register; the back end then waits
// and the two-entry queue fills before req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tags #(
   parameter int SETS      = 256,
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 48
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [ADDR_BITS-1:0]              req_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic [2:0]                             rsp_way,
   output logic                                   rsp_evicted,
   output logic [sacl_pkg::VICTIM_W-1:0]          rsp_victim_tag,
   output logic [sacl_pkg::COUNT_W-1:0]           rsp_read_hits,
   output logic [sacl_pkg::COUNT_W-1:0]           rsp_write_hits
);

   localparam int WCNT_W = $clog2(WAYS + 1);

   sacl_pkg::item_type front_item;
   sacl_pkg::item_type q_head;
   logic [WCNT_W-1:0]  ways_eff;
   logic               q_not_empty, q_full, q_pop, clearing, push;

   assign req_ready = !q_full && !clearing;
   assign push      = req_valid && req_ready;

   sacl_front #(
      .SETS      (SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_kind    (req_kind),
      .req_address (req_address),
      .item        (front_item),
      .ways_eff    (ways_eff)
   );

   sacl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (q_head)
   );

   sacl_back #(
      .SETS      (SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .ways_eff       (ways_eff),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_way        (rsp_way),
      .rsp_evicted    (rsp_evicted),
      .rsp_victim_tag (rsp_victim_tag),
      .rsp_read_hits  (rsp_read_hits),
      .rsp_write_hits (rsp_write_hits)
   );

endmodule

`default_nettype wire
